/* rtl/core/double_ended_queue_macros.svh */
// ----------------------------------------------------------------------------
// Double-ended queue assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// same-cycle implication, disabled in reset
`define DQ_ASSERT_IMPL(name, clk, rst, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication, disabled in reset
`define DQ_ASSERT_NEXT(name, clk, rst, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

/* rtl/core/dq_pkg.sv */
// ----------------------------------------------------------------------------
// Double-ended queue package
// Request and status codes, field widths and shared control types.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int REQ_W    = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_PEEK_FRONT = 3'd4,
    REQ_PEEK_BACK  = 3'd5
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_EMPTY_ERR  = 2'd1,
    ST_FULL_ERR   = 2'd2
  } status_t;

  typedef struct packed {
    logic re;
    logic we;
  } mem_cmd_t;

  typedef struct packed {
    status_t status;
    logic    rd;
    logic    empty;
  } meta_t;

endpackage

/* rtl/core/dq_store.sv */
// ----------------------------------------------------------------------------
// Double-ended queue entry store
// Single-port synchronous memory with registered read data.
// ----------------------------------------------------------------------------
module dq_store #(
  parameter int DEPTH      = dq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF,
  localparam int IDX_W     = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  dq_pkg::mem_cmd_t      cmd,
  input  logic [IDX_W-1:0]      addr,
  input  logic [DATA_WIDTH-1:0] wr_data,
  output logic [DATA_WIDTH-1:0] rd_data
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.re) begin
      rd_data <= mem[addr];
    end
  end

endmodule

/* rtl/core/dq_ctrl.sv */
// ----------------------------------------------------------------------------
// Double-ended queue pointer control
// Holds front index and entry count, decodes requests into store accesses.
// ----------------------------------------------------------------------------
module dq_ctrl #(
  parameter int DEPTH  = dq_pkg::DEPTH_DEF,
  localparam int IDX_W = $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [dq_pkg::REQ_W-1:0]    req_type,
  output dq_pkg::mem_cmd_t            cmd,
  output logic [IDX_W-1:0]            addr,
  output dq_pkg::meta_t               meta,
  output logic [CNT_W-1:0]            count_next
);

  localparam int SUM_W = CNT_W + 1;

  logic [IDX_W-1:0] front;
  logic [IDX_W-1:0] front_next;
  logic [CNT_W-1:0] count;
  logic             full;
  logic             empty;
  logic [IDX_W-1:0] front_dec;
  logic [IDX_W-1:0] front_inc;
  logic [SUM_W-1:0] sum_push;
  logic [SUM_W-1:0] sum_last;
  logic [IDX_W-1:0] back_push;
  logic [IDX_W-1:0] back_last;
  logic             rd;
  logic             wr;

  always_comb begin
    full      = (count == CNT_W'(DEPTH));
    empty     = (count == '0);
    front_dec = (front == '0) ? IDX_W'(DEPTH - 1) : front - IDX_W'(1);
    front_inc = (front == IDX_W'(DEPTH - 1)) ? '0 : front + IDX_W'(1);
    sum_push  = SUM_W'(front) + SUM_W'(count);
    sum_last  = sum_push - SUM_W'(1);
    back_push = (sum_push >= SUM_W'(DEPTH)) ? IDX_W'(sum_push - SUM_W'(DEPTH))
                                            : IDX_W'(sum_push);
    back_last = (sum_last >= SUM_W'(DEPTH)) ? IDX_W'(sum_last - SUM_W'(DEPTH))
                                            : IDX_W'(sum_last);
  end

  always_comb begin
    rd          = 1'b0;
    wr          = 1'b0;
    addr        = front;
    front_next  = front;
    count_next  = count;
    meta.status = dq_pkg::ST_OK;
    unique case (req_type)
      dq_pkg::REQ_PUSH_FRONT: begin
        if (full) begin
          meta.status = dq_pkg::ST_FULL_ERR;
        end else begin
          wr         = 1'b1;
          addr       = front_dec;
          front_next = front_dec;
          count_next = count + CNT_W'(1);
        end
      end
      dq_pkg::REQ_PUSH_BACK: begin
        if (full) begin
          meta.status = dq_pkg::ST_FULL_ERR;
        end else begin
          wr         = 1'b1;
          addr       = back_push;
          count_next = count + CNT_W'(1);
        end
      end
      dq_pkg::REQ_POP_FRONT: begin
        if (empty) begin
          meta.status = dq_pkg::ST_EMPTY_ERR;
        end else begin
          rd         = 1'b1;
          front_next = front_inc;
          count_next = count - CNT_W'(1);
        end
      end
      dq_pkg::REQ_POP_BACK: begin
        if (empty) begin
          meta.status = dq_pkg::ST_EMPTY_ERR;
        end else begin
          rd         = 1'b1;
          addr       = back_last;
          count_next = count - CNT_W'(1);
        end
      end
      dq_pkg::REQ_PEEK_FRONT: begin
        if (empty) begin
          meta.status = dq_pkg::ST_EMPTY_ERR;
        end else begin
          rd = 1'b1;
        end
      end
      dq_pkg::REQ_PEEK_BACK: begin
        if (empty) begin
          meta.status = dq_pkg::ST_EMPTY_ERR;
        end else begin
          rd   = 1'b1;
          addr = back_last;
        end
      end
      default: begin
      end
    endcase
    meta.rd    = rd;
    meta.empty = (count_next == '0);
    cmd.re     = accept & rd;
    cmd.we     = accept & wr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
    end else if (accept) begin
      front <= front_next;
      count <= count_next;
    end
  end

endmodule

/* rtl/core/double_ended_queue.sv */
// ----------------------------------------------------------------------------
// Double-ended queue
// Bounded deque in a ring store with push, pop and peek at either end. One
// request is taken per cycle while ready is high. The store read registers at
// the accepting edge, and the response register loads from the pending stage
// when it is empty or being taken. Pointer and count updates happen at
// acceptance, so a following request sees them at once, and a read of an
// entry written by the previous request reaches the store after its write.
// Ready drops only when the response register is full, stalled, and another
// response is pending.
// ----------------------------------------------------------------------------
module double_ended_queue #(
  parameter int DEPTH      = dq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  logic [dq_pkg::REQ_W-1:0]       req_type,
  input  logic [dq_pkg::VALUE_W-1:0]     push_value,
  output logic                           rsp_valid,
  input  logic                           rsp_ready,
  output logic [dq_pkg::VALUE_W-1:0]     read_value,
  output logic [dq_pkg::STATUS_W-1:0]    status,
  output logic                           is_empty,
  output logic [dq_pkg::COUNT_W-1:0]     entry_count
);

  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int WIDE_W = (DATA_WIDTH > dq_pkg::VALUE_W) ? DATA_WIDTH : dq_pkg::VALUE_W;
  localparam int CWID_W = (CNT_W > dq_pkg::COUNT_W) ? CNT_W : dq_pkg::COUNT_W;

  logic                  accept;
  dq_pkg::mem_cmd_t      cmd;
  logic [IDX_W-1:0]      addr;
  dq_pkg::meta_t         meta;
  logic [CNT_W-1:0]      count_next;
  logic [WIDE_W-1:0]     push_wide;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [DATA_WIDTH-1:0] rd_data;
  logic [WIDE_W-1:0]     rd_wide;
  logic [CWID_W-1:0]     cnt_wide;

  logic                  pend_valid;
  dq_pkg::meta_t         pend_meta;
  logic [CNT_W-1:0]      pend_count;
  logic                  pend_move;

  assign pend_move = pend_valid & (~rsp_valid | rsp_ready);
  assign req_ready = ~pend_valid | pend_move;
  assign accept    = req_valid & req_ready;
  assign push_wide = WIDE_W'(push_value);
  assign wr_data   = push_wide[DATA_WIDTH-1:0];
  assign rd_wide   = WIDE_W'(rd_data);
  assign cnt_wide  = CWID_W'(pend_count);

  dq_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .req_type   (req_type),
    .cmd        (cmd),
    .addr       (addr),
    .meta       (meta),
    .count_next (count_next)
  );

  dq_store #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_store (
    .clk     (clk),
    .cmd     (cmd),
    .addr    (addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  // pending stage: waits for the store read
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (accept) begin
      pend_valid <= 1'b1;
    end else if (pend_move) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_meta  <= meta;
      pend_count <= count_next;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (pend_move) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_move) begin
      read_value  <= pend_meta.rd ? rd_wide[dq_pkg::VALUE_W-1:0] : '0;
      status      <= pend_meta.status;
      is_empty    <= pend_meta.empty;
      entry_count <= cnt_wide[dq_pkg::COUNT_W-1:0];
    end
  end

endmodule

/* rtl/core/dq_checker.sv */
// ----------------------------------------------------------------------------
// Double-ended queue port checker
// Watches the response channel for handshake and status consistency.
// ----------------------------------------------------------------------------
`include "double_ended_queue_macros.svh"

module dq_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic [dq_pkg::VALUE_W-1:0]  read_value,
  input logic [dq_pkg::STATUS_W-1:0] status,
  input logic                        is_empty
);

  `DQ_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(status), "response dropped while stalled")
  `DQ_ASSERT_IMPL(a_empty_err, clk, rst, rsp_valid && status == dq_pkg::ST_EMPTY_ERR, is_empty, "empty error with entries held")
  `DQ_ASSERT_IMPL(a_full_err, clk, rst, rsp_valid && status == dq_pkg::ST_FULL_ERR, !is_empty, "full error on empty queue")
  `DQ_ASSERT_IMPL(a_err_zero, clk, rst, rsp_valid && status != dq_pkg::ST_OK, read_value == '0, "nonzero value on error")

endmodule

bind double_ended_queue dq_checker u_dq_checker (
  .clk        (clk),
  .rst        (rst),
  .rsp_valid  (rsp_valid),
  .rsp_ready  (rsp_ready),
  .read_value (read_value),
  .status     (status),
  .is_empty   (is_empty)
);

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue testbench
// Drives push, pop and peek requests at both ends of the ring-buffer deque,
// including the empty, full and spare request codes, through a directed
// table and then random phases that fill, drain and churn the queue. A local
// ring-buffer predictor computes replies not set in the table. Replies are
// compared in order; requests run in bursts and the reply side stalls.
// ----------------------------------------------------------------------------
module tb;
  import dq_pkg::*;

  localparam int DEPTH        = DEPTH_DEF;
  localparam int IDX_W        = $clog2(DEPTH);
  localparam int RANDOM_ITEMS = 1320;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 8;
  localparam int DIR_ROWS     = 20;

  localparam logic [REQ_W-1:0] REQ_SPARE_A = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_B = 3'd7;

  typedef struct packed {
    logic [VALUE_W-1:0] word;
    status_t            code;
    logic               empty;
    logic [COUNT_W-1:0] count;
  } reply_t;

  typedef struct packed {
    logic [REQ_W-1:0]   kind;
    logic [VALUE_W-1:0] word;
    bit                 rand_word;
    int unsigned        reps;
    bit                 typed;
    reply_t             reply;
  } dir_row_t;

  logic               clk;
  logic               rst;
  logic               req_valid;
  logic               req_ready;
  logic [REQ_W-1:0]   req_type;
  logic [VALUE_W-1:0] push_value;
  logic               rsp_valid;
  logic               rsp_ready;
  logic [VALUE_W-1:0] read_value;
  logic [STATUS_W-1:0] status;
  logic               is_empty;
  logic [COUNT_W-1:0] entry_count;

  logic [VALUE_W-1:0] ring [DEPTH];
  logic [IDX_W-1:0]   head_idx;
  logic [COUNT_W-1:0] fill_level;

  reply_t expected_replies[$];
  int     fail_cnt;
  int     mismatch_cnt;
  int     burst_left;
  int     idle_cycles;

  dir_row_t plan [DIR_ROWS] = '{
    '{REQ_PEEK_FRONT, 32'h0,        1'b0, 1,  1'b1, '{32'h0,        ST_EMPTY_ERR, 1'b1, 5'd0}},
    '{REQ_PEEK_BACK,  32'h0,        1'b0, 1,  1'b1, '{32'h0,        ST_EMPTY_ERR, 1'b1, 5'd0}},
    '{REQ_POP_FRONT,  32'h0,        1'b0, 1,  1'b1, '{32'h0,        ST_EMPTY_ERR, 1'b1, 5'd0}},
    '{REQ_POP_BACK,   32'h0,        1'b0, 1,  1'b1, '{32'h0,        ST_EMPTY_ERR, 1'b1, 5'd0}},
    '{REQ_SPARE_A,    32'h1234_5678, 1'b0, 1, 1'b1, '{32'h0,        ST_OK,        1'b1, 5'd0}},
    '{REQ_SPARE_B,    32'hFFFF_FFFF, 1'b0, 1, 1'b1, '{32'h0,        ST_OK,        1'b1, 5'd0}},
    '{REQ_PUSH_FRONT, 32'hFFFF_FFFF, 1'b0, 1, 1'b1, '{32'h0,        ST_OK,        1'b0, 5'd1}},
    '{REQ_PUSH_BACK,  32'h0,        1'b0, 1,  1'b1, '{32'h0,        ST_OK,        1'b0, 5'd2}},
    '{REQ_PEEK_FRONT, 32'h0,        1'b0, 1,  1'b1, '{32'hFFFF_FFFF, ST_OK,       1'b0, 5'd2}},
    '{REQ_PEEK_BACK,  32'hFFFF_FFFF, 1'b0, 1, 1'b1, '{32'h0,        ST_OK,        1'b0, 5'd2}},
    '{REQ_POP_BACK,   32'h0,        1'b0, 1,  1'b1, '{32'h0,        ST_OK,        1'b0, 5'd1}},
    '{REQ_POP_FRONT,  32'h0,        1'b0, 1,  1'b1, '{32'hFFFF_FFFF, ST_OK,       1'b1, 5'd0}},
    '{REQ_PUSH_FRONT, 32'h0,        1'b1, 16, 1'b0, '0},
    '{REQ_PUSH_BACK,  32'h5A5A_5A5A, 1'b0, 1, 1'b1, '{32'h0,        ST_FULL_ERR,  1'b0, 5'd16}},
    '{REQ_PUSH_FRONT, 32'hA5A5_A5A5, 1'b0, 1, 1'b1, '{32'h0,        ST_FULL_ERR,  1'b0, 5'd16}},
    '{REQ_SPARE_A,    32'h0,        1'b0, 1,  1'b0, '0},
    '{REQ_PEEK_BACK,  32'h0,        1'b0, 1,  1'b0, '0},
    '{REQ_PEEK_FRONT, 32'h0,        1'b0, 1,  1'b0, '0},
    '{REQ_POP_BACK,   32'h0,        1'b0, 1,  1'b0, '0},
    '{REQ_POP_FRONT,  32'h0,        1'b0, 1,  1'b0, '0}
  };

  double_ended_queue u_dut (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req_type    (req_type),
    .push_value  (push_value),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .read_value  (read_value),
    .status      (status),
    .is_empty    (is_empty),
    .entry_count (entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic reply_t predict_reply(input logic [REQ_W-1:0] kind,
                                           input logic [VALUE_W-1:0] word);
    reply_t r;
    int     back_pos;
    r        = '0;
    r.code   = ST_OK;
    back_pos = (int'(head_idx) + int'(fill_level) + DEPTH - 1) % DEPTH;
    case (kind)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (fill_level == DEPTH) begin
          r.code = ST_FULL_ERR;
        end else begin
          if (kind == REQ_PUSH_FRONT) begin
            head_idx       = IDX_W'((int'(head_idx) + DEPTH - 1) % DEPTH);
            ring[head_idx] = word;
          end else begin
            ring[(int'(head_idx) + int'(fill_level)) % DEPTH] = word;
          end
          fill_level = fill_level + 1'b1;
        end
      end
      REQ_POP_FRONT, REQ_POP_BACK, REQ_PEEK_FRONT, REQ_PEEK_BACK: begin
        if (fill_level == 0) begin
          r.code = ST_EMPTY_ERR;
        end else begin
          if (kind == REQ_POP_FRONT || kind == REQ_PEEK_FRONT) r.word = ring[head_idx];
          else r.word = ring[back_pos];
          if (kind == REQ_POP_FRONT) begin
            head_idx   = IDX_W'((int'(head_idx) + 1) % DEPTH);
            fill_level = fill_level - 1'b1;
          end else if (kind == REQ_POP_BACK) begin
            fill_level = fill_level - 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.empty = (fill_level == 0);
    r.count = fill_level;
    return r;
  endfunction

  function automatic logic [VALUE_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return 32'h1 << $urandom_range(0, 31);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [REQ_W-1:0] pick_request(input int push_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) return $urandom_range(0, 1) ? REQ_SPARE_A : REQ_SPARE_B;
    if ($urandom_range(0, 99) < push_pct)
      return $urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
    case ($urandom_range(0, 9))
      0, 1, 2: return REQ_POP_FRONT;
      3, 4, 5: return REQ_POP_BACK;
      6, 7:    return REQ_PEEK_FRONT;
      default: return REQ_PEEK_BACK;
    endcase
  endfunction

  // hold the request until taken, then record its reply
  task automatic send_request(input logic [REQ_W-1:0] kind, input logic [VALUE_W-1:0] word,
                              input bit typed, input reply_t typed_reply);
    reply_t predicted;
    if (burst_left == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(1, 12);
    end
    burst_left--;
    req_valid  <= 1'b1;
    req_type   <= kind;
    push_value <= word;
    do @(posedge clk); while (!(req_valid && req_ready));
    predicted = predict_reply(kind, word);
    expected_replies.push_back(typed ? typed_reply : predicted);
    @(negedge clk);
  endtask

  initial begin : stimulus
    int push_pct;
    int phase_left;
    rst        = 1'b1;
    req_valid  = 1'b0;
    req_type   = '0;
    push_value = '0;
    head_idx   = '0;
    fill_level = '0;
    fail_cnt   = 0;
    mismatch_cnt = 0;
    burst_left = 0;
    phase_left = 0;
    push_pct   = 50;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (plan[i]) begin
      for (int n = 0; n < plan[i].reps; n++) begin
        send_request(plan[i].kind, plan[i].rand_word ? pick_word() : plan[i].word,
                     plan[i].typed, plan[i].reply);
      end
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(8, 48);
        case ($urandom_range(0, 2))
          0:       push_pct = 80;
          1:       push_pct = 20;
          default: push_pct = 50;
        endcase
      end
      phase_left--;
      send_request(pick_request(push_pct), pick_word(), 1'b0, '0);
    end
    req_valid <= 1'b0;

    while (expected_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("double_ended_queue regression: pass");
    end else begin
      $display("double_ended_queue regression: fail");
    end
    $finish;
  end

  initial begin : reply_stall
    int cyc;
    int mode;
    cyc       = 0;
    mode      = 0;
    rsp_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (cyc % 64 == 0) mode = $urandom_range(0, 3);
      case (mode)
        0:       rsp_ready <= 1'b1;
        1:       rsp_ready <= $urandom_range(0, 1);
        2:       rsp_ready <= (cyc % 4 == 0);
        default: rsp_ready <= (cyc % 16 < 3);
      endcase
      cyc++;
    end
  end

  always @(posedge clk) begin : reply_check
    reply_t exp_r;
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_replies.size() == 0) begin
        fail_cnt++;
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected reply: value=%h status=%0d empty=%0b count=%0d",
                   read_value, status, is_empty, entry_count);
      end else begin
        exp_r = expected_replies.pop_front();
        if (read_value !== exp_r.word || status !== exp_r.code ||
            is_empty !== exp_r.empty || entry_count !== exp_r.count) begin
          fail_cnt++;
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("reply mismatch: exp value=%h status=%0d empty=%0b count=%0d, got value=%h status=%0d empty=%0b count=%0d",
                     exp_r.word, exp_r.code, exp_r.empty, exp_r.count,
                     read_value, status, is_empty, entry_count);
        end
      end
    end
  end

  initial begin : watchdog
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("double_ended_queue regression: fail");
    $finish;
  end

endmodule
